@@ hdl/wstd_pkg.sv @@
`timescale 1ns / 1ps

package wstd_pkg;

  localparam int OP_BITS     = 2;
  localparam int STATUS_BITS = 2;

  typedef enum logic [OP_BITS-1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_TAKE = 2'd2
  } op_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic    wr_en;
    logic    rd_en;
    status_t status;
  } ctrl_flags_t;

endpackage

@@ hdl/wstd_if.sv @@
`timescale 1ns / 1ps

interface wstd_in_if #(
  parameter int HANDLE_BITS = 32
) ();
  import wstd_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [OP_BITS-1:0]     operation;
  logic [HANDLE_BITS-1:0] task_handle;

  modport source (output valid, output operation, output task_handle, input ready);
  modport sink   (input valid, input operation, input task_handle, output ready);
endinterface

interface wstd_out_if #(
  parameter int HANDLE_BITS = 32,
  parameter int DEPTH       = 1024
) ();
  import wstd_pkg::*;

  localparam int OCC_BITS = $clog2(DEPTH + 1);

  logic                   valid;
  logic                   ready;
  logic [STATUS_BITS-1:0] status;
  logic [HANDLE_BITS-1:0] task_out;
  logic [OCC_BITS-1:0]    occupancy;

  modport source (output valid, output status, output task_out, output occupancy,
                  input ready);
  modport sink   (input valid, input status, input task_out, input occupancy,
                  output ready);
endinterface

@@ hdl/work_stealing_task_deque_top.sv @@
`timescale 1ns / 1ps

// Work-stealing task deque on a ring of DEPTH handles. Each input item is a
// push at the top, a pop from the top (newest first), a take from the base
// (oldest first) or an unused code that leaves the deque unchanged, and yields
// exactly one result item with a status (ok, empty or full), the removed
// handle (zero unless a pop or take succeeded) and the occupancy after the
// operation. One item is accepted per cycle while the result side keeps up;
// an accepted item waits in the input register and its result is held in the
// output register; the handle read from memory is registered at the same edge
// as the result. The memory has no reset and no clearing pass, so the block
// takes items as soon as reset is released.
module work_stealing_task_deque_top #(
  parameter int DEPTH       = 1024,
  parameter int HANDLE_BITS = 32
) (
  input logic       clk,
  input logic       rst_n,
  wstd_in_if.sink   in_ch,
  wstd_out_if.source out_ch
);
  import wstd_pkg::*;

  localparam int IDX_BITS = $clog2(DEPTH);
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic                   adv;
  logic                   a_valid_r;
  op_t                    a_op_r;
  logic [HANDLE_BITS-1:0] a_handle_r;

  ctrl_flags_t            flags;
  logic [IDX_BITS-1:0]    addr;
  logic [CNT_BITS-1:0]    occ;
  logic                   fire;

  logic                   out_valid_r;
  status_t                status_r;
  logic [CNT_BITS-1:0]    occ_r;
  logic                   rd_r;
  logic [HANDLE_BITS-1:0] rdata;

  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;
  assign fire        = adv && a_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (adv) begin
      a_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_op_r     <= op_t'(in_ch.operation);
      a_handle_r <= in_ch.task_handle;
    end
  end

  wstd_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .op        (a_op_r),
    .flags     (flags),
    .addr      (addr),
    .occupancy (occ)
  );

  wstd_ram #(
    .WIDTH (HANDLE_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (flags.wr_en),
    .waddr (addr),
    .wdata (a_handle_r),
    .re    (flags.rd_en),
    .raddr (addr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      status_r <= flags.status;
      occ_r    <= occ;
      rd_r     <= flags.rd_en;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = status_r;
  assign out_ch.task_out  = rd_r ? rdata : '0;
  assign out_ch.occupancy = occ_r;

  a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r == ST_FULL) |-> (occ_r == CNT_BITS'(DEPTH)))
    else $error("full status with spare room");

  a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r == ST_EMPTY) |-> (occ_r == '0))
    else $error("empty status with handles held");

  a_read_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && rd_r) |-> (status_r == ST_OK))
    else $error("handle returned with a failing status");

endmodule

@@ hdl/wstd_ram.sv @@
`timescale 1ns / 1ps

module wstd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/wstd_ctrl.sv @@
`timescale 1ns / 1ps

module wstd_ctrl #(
  parameter int DEPTH = 1024
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         fire,
  input  wstd_pkg::op_t                op,
  output wstd_pkg::ctrl_flags_t        flags,
  output logic [$clog2(DEPTH)-1:0]     addr,
  output logic [$clog2(DEPTH+1)-1:0]   occupancy
);
  import wstd_pkg::*;

  localparam int IDX_BITS = $clog2(DEPTH);
  localparam int CNT_BITS = $clog2(DEPTH + 1);
  localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(DEPTH - 1);
  localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(DEPTH);

  logic [IDX_BITS-1:0] top_r, top_nxt;
  logic [IDX_BITS-1:0] base_r, base_nxt;
  logic [CNT_BITS-1:0] count_r, count_nxt;
  logic [IDX_BITS-1:0] top_inc, top_dec, base_inc;
  logic                is_full, is_empty;

  assign top_inc  = (top_r == LAST_IDX) ? '0 : top_r + IDX_BITS'(1);
  assign top_dec  = (top_r == '0) ? LAST_IDX : top_r - IDX_BITS'(1);
  assign base_inc = (base_r == LAST_IDX) ? '0 : base_r + IDX_BITS'(1);
  assign is_full  = (count_r == FULL_CNT);
  assign is_empty = (count_r == '0);

  always_comb begin
    top_nxt      = top_r;
    base_nxt     = base_r;
    count_nxt    = count_r;
    addr         = top_r;
    flags.wr_en  = 1'b0;
    flags.rd_en  = 1'b0;
    flags.status = ST_OK;
    case (op)
      OP_PUSH: begin
        if (is_full) begin
          flags.status = ST_FULL;
        end else begin
          flags.wr_en = fire;
          top_nxt     = top_inc;
          count_nxt   = count_r + CNT_BITS'(1);
        end
      end
      OP_POP: begin
        addr = top_dec;
        if (is_empty) begin
          flags.status = ST_EMPTY;
        end else begin
          flags.rd_en = fire;
          top_nxt     = top_dec;
          count_nxt   = count_r - CNT_BITS'(1);
        end
      end
      OP_TAKE: begin
        addr = base_r;
        if (is_empty) begin
          flags.status = ST_EMPTY;
        end else begin
          flags.rd_en = fire;
          base_nxt    = base_inc;
          count_nxt   = count_r - CNT_BITS'(1);
        end
      end
      default: begin
        flags.status = ST_OK;
      end
    endcase
  end

  assign occupancy = count_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r   <= '0;
      base_r  <= '0;
      count_r <= '0;
    end else if (fire) begin
      top_r   <= top_nxt;
      base_r  <= base_nxt;
      count_r <= count_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("entry count above capacity");

  a_ends_meet: assert property (@(posedge clk) disable iff (!rst_n)
    (is_empty || is_full) |-> (top_r == base_r))
    else $error("top and base disagree with entry count");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(count_r))
    else $error("entry count moved without an item");

endmodule

@@ bench/tb_work_stealing_task_deque_top.sv @@
`timescale 1ns / 1ps

module tb_work_stealing_task_deque_top;
  import wstd_pkg::*;

  localparam int DEPTH       = 1024;
  localparam int HANDLE_BITS = 32;
  localparam int OCC_BITS    = $clog2(DEPTH + 1);
  localparam int IDX_BITS    = $clog2(DEPTH);
  localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;
  localparam logic [HANDLE_BITS-1:0] ALL_ONES = '1;

  typedef struct {
    status_t                status;
    logic [HANDLE_BITS-1:0] handle;
    logic [OCC_BITS-1:0]    occupancy;
  } deque_reply_t;

  logic clk = 1'b0;
  logic rst_n;

  wstd_in_if  #(.HANDLE_BITS(HANDLE_BITS))                in_ch ();
  wstd_out_if #(.HANDLE_BITS(HANDLE_BITS), .DEPTH(DEPTH)) out_ch ();

  work_stealing_task_deque_top #(
    .DEPTH      (DEPTH),
    .HANDLE_BITS(HANDLE_BITS)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  logic [HANDLE_BITS-1:0] mirror_slots [DEPTH];
  logic [IDX_BITS-1:0]    mirror_top  = '0;
  logic [IDX_BITS-1:0]    mirror_base = '0;
  int unsigned            mirror_held = 0;

  deque_reply_t expected_replies [$];

  int errors        = 0;
  int replies_seen  = 0;
  int n_push        = 0;
  int n_pop         = 0;
  int n_take        = 0;
  int n_unused      = 0;
  int n_refused     = 0;
  int n_empty       = 0;
  int peak_held     = 0;
  int burst_left    = 0;

  task automatic flag_error(input string msg);
    errors++;
    if (errors <= 40) $display("ERROR @%0t: %s", $time, msg);
  endtask

  function automatic logic [IDX_BITS-1:0] ring_next(input logic [IDX_BITS-1:0] idx);
    return (idx == IDX_BITS'(DEPTH - 1)) ? '0 : idx + 1'b1;
  endfunction

  function automatic deque_reply_t apply_deque_op(input logic [OP_BITS-1:0] op_code,
                                                  input logic [HANDLE_BITS-1:0] handle);
    deque_reply_t r;
    r.status = ST_OK;
    r.handle = '0;
    case (op_code)
      OP_PUSH: begin
        n_push++;
        if (mirror_held >= DEPTH) begin
          r.status = ST_FULL;
          n_refused++;
        end else begin
          mirror_slots[mirror_top] = handle;
          mirror_top = ring_next(mirror_top);
          mirror_held++;
        end
      end
      OP_POP: begin
        n_pop++;
        if (mirror_held == 0) begin
          r.status = ST_EMPTY;
          n_empty++;
        end else begin
          mirror_top = (mirror_top == '0) ? IDX_BITS'(DEPTH - 1) : mirror_top - 1'b1;
          r.handle = mirror_slots[mirror_top];
          mirror_held--;
        end
      end
      OP_TAKE: begin
        n_take++;
        if (mirror_held == 0) begin
          r.status = ST_EMPTY;
          n_empty++;
        end else begin
          r.handle = mirror_slots[mirror_base];
          mirror_base = ring_next(mirror_base);
          mirror_held--;
        end
      end
      default: begin
        n_unused++;
      end
    endcase
    if (mirror_held > peak_held) peak_held = mirror_held;
    r.occupancy = OCC_BITS'(mirror_held);
    return r;
  endfunction

  function automatic logic [OP_BITS-1:0] pick_op(input int w_push, input int w_pop,
                                                 input int w_take, input int w_spare);
    int roll;
    roll = $urandom_range(0, w_push + w_pop + w_take + w_spare - 1);
    if (roll < w_push) return OP_PUSH;
    if (roll < w_push + w_pop) return OP_POP;
    if (roll < w_push + w_pop + w_take) return OP_TAKE;
    return OP_UNUSED;
  endfunction

  function automatic logic [HANDLE_BITS-1:0] pick_handle();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return ALL_ONES;
      default: return HANDLE_BITS'($urandom);
    endcase
  endfunction

  task automatic send_op(input logic [OP_BITS-1:0] op_code,
                         input logic [HANDLE_BITS-1:0] handle);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        burst_left = $urandom_range(40, 120);
        gap = 0;
      end else begin
        burst_left = $urandom_range(1, 16);
        gap = $urandom_range(0, 6);
      end
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid       <= 1'b1;
    in_ch.operation   <= op_code;
    in_ch.task_handle <= handle;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_replies.push_back(apply_deque_op(op_code, handle));
  endtask

  task automatic settle_replies();
    int waited;
    waited = 0;
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_replies.size() != 0 && waited < 50000) begin
      @(posedge clk);
      waited++;
    end
  endtask

  task automatic test_directed_edges();
    send_op(OP_TAKE, 32'h1234_5678);
    send_op(OP_POP, ALL_ONES);
    send_op(OP_UNUSED, ALL_ONES);
    send_op(OP_PUSH, '0);
    send_op(OP_PUSH, ALL_ONES);
    send_op(OP_PUSH, 32'hA5A5_A5A5);
    send_op(OP_PUSH, 32'h5A5A_5A5A);
    send_op(OP_UNUSED, 32'hDEAD_BEEF);
    send_op(OP_POP, 32'hDEAD_BEEF);
    send_op(OP_TAKE, '0);
    send_op(OP_POP, '0);
    send_op(OP_TAKE, '0);
    send_op(OP_POP, '0);
    send_op(OP_TAKE, '0);
    send_op(OP_PUSH, 32'h0000_0001);
    send_op(OP_POP, '0);
    send_op(OP_PUSH, 32'h8000_0000);
    send_op(OP_TAKE, '0);
    send_op(OP_UNUSED, '0);
  endtask

  task automatic test_low_occupancy_mix();
    repeat (60) send_op(pick_op(30, 30, 30, 10), pick_handle());
  endtask

  task automatic test_fill_to_full();
    while (mirror_held < DEPTH) send_op(pick_op(96, 1, 2, 1), pick_handle());
    settle_replies();
    repeat (30) send_op(pick_op(60, 15, 15, 10), pick_handle());
  endtask

  task automatic test_drain_to_empty();
    while (mirror_held > 0) send_op(pick_op(1, 10, 88, 1), pick_handle());
    repeat (8) send_op(pick_op(0, 45, 45, 10), pick_handle());
  endtask

  task automatic test_steal_stream();
    repeat (60) send_op(pick_op(50, 5, 40, 5), pick_handle());
    repeat (40) send_op(pick_op(40, 35, 20, 5), pick_handle());
  endtask

  int rx_tick  = 0;
  int rx_mode  = 0;
  int rx_hold  = 0;
  logic rx_level = 1'b1;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      rx_tick++;
      if (rx_tick % 150 == 0) rx_mode = $urandom_range(0, 3);
      case (rx_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= ($urandom_range(0, 3) != 0);
        2: out_ch.ready <= ((rx_tick % 7) < 5);
        default: begin
          if (rx_hold == 0) begin
            rx_level = !rx_level;
            rx_hold = rx_level ? $urandom_range(1, 8) : $urandom_range(4, 16);
          end
          rx_hold--;
          out_ch.ready <= rx_level;
        end
      endcase
    end
  end

  always @(posedge clk) begin
    deque_reply_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      replies_seen++;
      if (expected_replies.size() == 0) begin
        flag_error($sformatf("result with nothing pending: status %0d handle %h occ %0d",
                             out_ch.status, out_ch.task_out, out_ch.occupancy));
      end else begin
        want = expected_replies.pop_front();
        if (out_ch.status !== want.status)
          flag_error($sformatf("result %0d status %0d, want %0d",
                               replies_seen, out_ch.status, want.status));
        if (out_ch.task_out !== want.handle)
          flag_error($sformatf("result %0d handle %h, want %h",
                               replies_seen, out_ch.task_out, want.handle));
        if (out_ch.occupancy !== want.occupancy)
          flag_error($sformatf("result %0d occupancy %0d, want %0d",
                               replies_seen, out_ch.occupancy, want.occupancy));
      end
    end
  end

  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.operation   <= OP_PUSH;
    in_ch.task_handle <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_edges();
    settle_replies();
    test_low_occupancy_mix();
    settle_replies();
    test_fill_to_full();
    settle_replies();
    test_drain_to_empty();
    settle_replies();
    test_steal_stream();
    settle_replies();
    repeat (10) @(posedge clk);

    if (expected_replies.size() != 0)
      flag_error($sformatf("%0d results never arrived", expected_replies.size()));

    $display("Ran %0d operations: %0d push, %0d pop, %0d take, %0d unused code",
             n_push + n_pop + n_take + n_unused, n_push, n_pop, n_take, n_unused);
    $display("Saw %0d pushes refused at capacity, %0d empty replies, peak occupancy %0d/%0d",
             n_refused, n_empty, peak_held, DEPTH);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
